### hw/rtl/jem_pkg.sv
// ----------------------------------------------------------------------------
// jem_pkg
// Shared types, constants and helpers for the julia escape modulus block.
// ----------------------------------------------------------------------------
package jem_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned ProdW       = 64;
  localparam int unsigned ModW        = 31;
  localparam int unsigned IterCfgW    = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned RootSteps   = 32;
  localparam int unsigned RootCntW    = $clog2(RootSteps);
  localparam int unsigned FracBitsDef = 28;
  localparam int unsigned IterBitsDef = 16;

  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_C_REAL   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_C_IMAG   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAD,
    ST_X0,
    ST_Y0,
    ST_XY,
    ST_UPD,
    ST_SQX,
    ST_SQY,
    ST_TEST,
    ST_ROOT,
    ST_FIN_ZERO,
    ST_FIN_ROOT
  } jem_state_e;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY,
    MUL_RR
  } mul_sel_e;

  typedef struct packed {
    logic     load_start;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     update;
    logic     load_root;
    logic     root_step;
    logic     load_out;
    logic     out_zero;
  } jem_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic last_iter;
    logic escaped;
    logic root_last;
    logic out_free;
  } jem_sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = -hi - ProdW'(1);
    if (v > hi) begin
      sat32 = DataW'(hi);
    end else if (v < lo) begin
      sat32 = DataW'(lo);
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

### hw/rtl/jem_ctrl.sv
// ----------------------------------------------------------------------------
// jem_ctrl
// Sequencer: start products, iteration steps, escape test, root and output.
// ----------------------------------------------------------------------------
module jem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jem_pkg::jem_sts_t sts_i,
  output jem_pkg::jem_cmd_t cmd_o
);
  import jem_pkg::*;

  jem_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RAD;
      end
      ST_RAD: begin
        state_d = sts_i.limit_zero ? ST_FIN_ZERO : ST_X0;
      end
      ST_X0:  state_d = ST_Y0;
      ST_Y0:  state_d = ST_XY;
      ST_XY:  state_d = ST_UPD;
      ST_UPD: state_d = ST_SQX;
      ST_SQX: state_d = ST_SQY;
      ST_SQY: state_d = ST_TEST;
      ST_TEST: begin
        if (sts_i.last_iter) begin
          state_d = ST_FIN_ZERO;
        end else if (sts_i.escaped) begin
          state_d = ST_ROOT;
        end else begin
          state_d = ST_XY;
        end
      end
      ST_ROOT: begin
        if (sts_i.root_last) state_d = ST_FIN_ROOT;
      end
      ST_FIN_ZERO, ST_FIN_ROOT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.load_start = in_valid_i;
      end
      ST_RAD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RR;
      end
      ST_X0, ST_SQX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XX;
      end
      ST_Y0, ST_SQY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_YY;
      end
      ST_XY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XY;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
      end
      ST_TEST: begin
        cmd_o.load_root = 1'b1;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
      end
      ST_FIN_ZERO: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_zero = 1'b1;
      end
      ST_FIN_ROOT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### hw/rtl/jem_dp.sv
// ----------------------------------------------------------------------------
// jem_dp
// Datapath: shared signed multiplier, z update with saturation, escape
// compare, bit-serial square root and the output register.
// ----------------------------------------------------------------------------
module jem_dp #(
  parameter int unsigned FRAC_BITS = jem_pkg::FracBitsDef,
  parameter int unsigned ITER_BITS = jem_pkg::IterBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  jem_pkg::jem_cmd_t                    cmd_i,
  output jem_pkg::jem_sts_t                    sts_o,
  input  logic signed [jem_pkg::DataW-1:0]     start_real_i,
  input  logic signed [jem_pkg::DataW-1:0]     start_imag_i,
  input  logic [ITER_BITS-1:0]                 limit_i,
  input  logic signed [jem_pkg::DataW-1:0]     c_real_i,
  input  logic signed [jem_pkg::DataW-1:0]     c_imag_i,
  input  logic [jem_pkg::ModW-1:0]             radius_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [jem_pkg::ModW-1:0]             escape_modulus_o
);
  import jem_pkg::*;

  logic signed [DataW-1:0] x_q, y_q;
  logic [ProdW-1:0]        xx_q, yy_q, r2_q;
  logic signed [ProdW-1:0] xy_q;
  logic [ITER_BITS-1:0]    iter_q;
  logic [ProdW-1:0]        rn_q, res_q, rbit_q;
  logic [RootCntW-1:0]     rcnt_q;
  logic                    out_valid_q;
  logic [ModW-1:0]         out_q;

  logic signed [DataW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic [ProdW-1:0]        sum;
  logic signed [ProdW-1:0] diff, nx_w, ny_w;
  logic [ProdW-1:0]        trial;
  logic                    fits;
  logic [ModW-1:0]         root_sat;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XX: begin
        op_a = x_q;
        op_b = x_q;
      end
      MUL_YY: begin
        op_a = y_q;
        op_b = y_q;
      end
      MUL_XY: begin
        op_a = x_q;
        op_b = y_q;
      end
      default: begin
        op_a = signed'({1'b0, radius_i});
        op_b = signed'({1'b0, radius_i});
      end
    endcase
  end

  assign prod  = op_a * op_b;
  assign sum   = xx_q + yy_q;
  assign diff  = signed'(xx_q) - signed'(yy_q);
  assign nx_w  = (diff >>> FRAC_BITS) + ProdW'(c_real_i);
  assign ny_w  = (xy_q >>> (FRAC_BITS - 1)) + ProdW'(c_imag_i);
  assign trial = res_q + rbit_q;
  assign fits  = rn_q >= trial;

  assign root_sat = (res_q > ProdW'({ModW{1'b1}})) ? {ModW{1'b1}} : res_q[ModW-1:0];

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      x_q <= start_real_i;
      y_q <= start_imag_i;
    end else if (cmd_i.update) begin
      x_q <= sat32(nx_w);
      y_q <= sat32(ny_w);
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_XX:  xx_q <= unsigned'(prod);
        MUL_YY:  yy_q <= unsigned'(prod);
        MUL_XY:  xy_q <= prod;
        default: r2_q <= unsigned'(prod);
      endcase
    end
    if (cmd_i.load_root) begin
      rn_q   <= sum;
      res_q  <= '0;
      rbit_q <= ProdW'(1) << (ProdW - 2);
    end else if (cmd_i.root_step) begin
      rn_q   <= fits ? rn_q - trial : rn_q;
      res_q  <= fits ? (res_q >> 1) + rbit_q : res_q >> 1;
      rbit_q <= rbit_q >> 2;
    end
    if (cmd_i.load_out) begin
      out_q <= cmd_i.out_zero ? '0 : root_sat;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_start) begin
        iter_q <= '0;
      end else if (cmd_i.update) begin
        iter_q <= iter_q + ITER_BITS'(1);
      end
      if (cmd_i.load_root) begin
        rcnt_q <= '0;
      end else if (cmd_i.root_step) begin
        rcnt_q <= rcnt_q + RootCntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // a zero limit or a zero radius stops the loop before the first step
  assign sts_o.limit_zero = (limit_i == '0) || (radius_i == '0);
  assign sts_o.last_iter  = (iter_q == limit_i);
  assign sts_o.escaped    = (sum >= r2_q);
  assign sts_o.root_last  = (rcnt_q == RootCntW'(RootSteps - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign escape_modulus_o = out_q;

endmodule

### hw/rtl/julia_escape_modulus.sv
// ----------------------------------------------------------------------------
// julia_escape_modulus
// Julia set escape test: iterates z = z^2 + c from a start point and
// returns |z| at escape, or 0 when the iteration limit is reached or the radius is zero.
// ----------------------------------------------------------------------------
// One point is worked at a time. Each iteration runs three products through
// the one shared 32x32 multiplier plus an update and an escape compare, and the
// modulus comes from a one-bit-per-cycle square root that runs only once, after
// escape. A finished result waits in the output register while the next point
// is taken.
module julia_escape_modulus #(
  parameter int unsigned FRAC_BITS = jem_pkg::FracBitsDef,
  parameter int unsigned ITER_BITS = jem_pkg::IterBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [jem_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [jem_pkg::DataW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [jem_pkg::DataW-1:0] start_real_i,
  input  logic signed [jem_pkg::DataW-1:0] start_imag_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [jem_pkg::ModW-1:0]         escape_modulus_o
);
  import jem_pkg::*;

  localparam logic [ProdW-1:0] RadRaw   = ProdW'(3) << FRAC_BITS;
  localparam logic [ProdW-1:0] RadMax   = ProdW'({ModW{1'b1}});
  localparam logic [ModW-1:0]  RadReset = (RadRaw > RadMax) ? {ModW{1'b1}} : RadRaw[ModW-1:0];

  logic [IterCfgW-1:0]     max_iter_q;
  logic signed [DataW-1:0] c_real_q, c_imag_q;
  logic [ModW-1:0]         radius_q;
  jem_cmd_t                cmd;
  jem_sts_t                sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= '0;
      c_real_q   <= '0;
      c_imag_q   <= '0;
      radius_q   <= RadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[IterCfgW-1:0];
        CFG_C_REAL:   c_real_q   <= signed'(cfg_data_i);
        CFG_C_IMAG:   c_imag_q   <= signed'(cfg_data_i);
        CFG_RADIUS:   radius_q   <= cfg_data_i[ModW-1:0];
        default:      radius_q   <= radius_q;
      endcase
    end
  end

  jem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jem_dp #(
    .FRAC_BITS (FRAC_BITS),
    .ITER_BITS (ITER_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .start_real_i     (start_real_i),
    .start_imag_i     (start_imag_i),
    .limit_i          (ITER_BITS'(max_iter_q)),
    .c_real_i         (c_real_q),
    .c_imag_i         (c_imag_q),
    .radius_i         (radius_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .escape_modulus_o (escape_modulus_o)
  );

endmodule

### tb/sv/julia_escape_modulus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_modulus_checker
// Watches the register port and both point channels of the escape block. It
// keeps its own copy of the registers, works out the escape modulus of every
// accepted start point and compares each returned result, in order, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module julia_escape_modulus_checker #(
  parameter int unsigned FRAC_BITS = jem_pkg::FracBitsDef,
  parameter int unsigned ITER_BITS = jem_pkg::IterBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [jem_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [jem_pkg::DataW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic signed [jem_pkg::DataW-1:0] start_real_i,
  input  logic signed [jem_pkg::DataW-1:0] start_imag_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [jem_pkg::ModW-1:0]         escape_modulus_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      escaped_o
);
  import jem_pkg::*;

  localparam logic [ProdW-1:0] RadiusScaled = 64'd3 << FRAC_BITS;
  localparam logic [ModW-1:0]  RadiusReset  = (RadiusScaled > 64'h7FFF_FFFF) ?
                                              31'h7FFF_FFFF : RadiusScaled[ModW-1:0];

  typedef struct {
    logic signed [DataW-1:0] start_real;
    logic signed [DataW-1:0] start_imag;
    logic [ModW-1:0]         modulus;
  } escape_expect_t;

  escape_expect_t          modulus_q[$];
  escape_expect_t          head_v;
  logic [IterCfgW-1:0]     iter_limit;
  logic signed [ProdW-1:0] c_re;
  logic signed [ProdW-1:0] c_im;
  logic [ModW-1:0]         radius;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    escaped_o    = 0;
  end

  function automatic logic signed [ProdW-1:0] clamp_word(logic signed [ProdW-1:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic logic [ProdW-1:0] isqrt64(logic [ProdW-1:0] n);
    logic [ProdW-1:0] rem;
    logic [ProdW-1:0] res;
    logic [ProdW-1:0] bit_v;
    int               k;
    rem   = n;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (k = 0; k < RootSteps; k++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [ModW-1:0] predict_modulus(logic signed [DataW-1:0] sr,
                                                      logic signed [DataW-1:0] si);
    logic signed [ProdW-1:0] x;
    logic signed [ProdW-1:0] y;
    logic signed [ProdW-1:0] sq_diff;
    logic signed [ProdW-1:0] xy_prod;
    logic [ProdW-1:0]        mag_sq;
    logic [ProdW-1:0]        mag;
    int unsigned             limit_v;
    int unsigned             steps;
    x       = sr;
    y       = si;
    limit_v = int'(iter_limit) & ((32'd1 << ITER_BITS) - 32'd1);
    steps   = 0;
    mag     = '0;
    while (steps < limit_v && mag < ProdW'(radius)) begin
      sq_diff = x * x - y * y;
      xy_prod = x * y;
      x       = clamp_word((sq_diff >>> FRAC_BITS) + c_re);
      y       = clamp_word((xy_prod >>> (FRAC_BITS - 1)) + c_im);
      mag_sq  = x * x + y * y;
      mag     = isqrt64(mag_sq);
      if (mag > 64'h7FFF_FFFF) begin
        mag = 64'h7FFF_FFFF;
      end
      steps++;
    end
    return (steps >= limit_v) ? '0 : mag[ModW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit <= '0;
      c_re       <= '0;
      c_im       <= '0;
      radius     <= RadiusReset;
      modulus_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAX_ITER: iter_limit <= cfg_data_i[IterCfgW-1:0];
          CFG_C_REAL:   c_re <= {{(ProdW-DataW){cfg_data_i[DataW-1]}}, cfg_data_i};
          CFG_C_IMAG:   c_im <= {{(ProdW-DataW){cfg_data_i[DataW-1]}}, cfg_data_i};
          CFG_RADIUS:   radius <= cfg_data_i[ModW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (modulus_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no point outstanding",
                                    escape_modulus_i));
        end else begin
          head_v = modulus_q.pop_front();
          if (escape_modulus_i !== head_v.modulus) begin
            report_mismatch($sformatf("start (%0d, %0d): modulus %0d, predicted %0d",
                                      head_v.start_real, head_v.start_imag,
                                      escape_modulus_i, head_v.modulus));
          end
          if (head_v.modulus != '0) begin
            escaped_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        modulus_q.push_back('{start_real_i, start_imag_i,
                              predict_modulus(start_real_i, start_imag_i)});
      end
      pending_o = modulus_q.size();
    end
  end

endmodule

### tb/sv/julia_escape_modulus_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_modulus_tb
// Drives start points and register settings into the escape block with random
// gaps and output stalls, including long output hold-offs, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module julia_escape_modulus_tb;
  import jem_pkg::*;

  localparam int unsigned FracBits      = FracBitsDef;
  localparam int unsigned TotalItems    = 1550;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 50;
  localparam longint     TimeoutCycles  = 20_000_000;
  localparam longint     ClkPeriod      = 10;

  localparam logic signed [DataW-1:0] WordMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] WordMin = 32'sh8000_0000;
  localparam logic [ModW-1:0] RadiusThree = 31'(64'd3 << FracBits);
  localparam logic [ModW-1:0] RadiusTwo   = 31'(64'd2 << FracBits);
  localparam logic signed [DataW-1:0] QThree    = 32'sd3 <<< FracBits;
  localparam logic signed [DataW-1:0] QHalf     = 32'sd1 <<< (FracBits - 1);
  localparam logic signed [DataW-1:0] CRealDemo = -32'sd214748364;
  localparam logic signed [DataW-1:0] CImagDemo = 32'sd41875931;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIdxW-1:0]      cfg_index;
  logic [DataW-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [DataW-1:0] start_real;
  logic signed [DataW-1:0] start_imag;
  logic                    out_valid;
  logic                    out_stall;
  logic [ModW-1:0]         escape_modulus;

  logic        no_idle;
  logic        hold_off_req;
  int unsigned items_sent;
  int unsigned settings_applied;
  int unsigned hold_offs;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned escaped;

  julia_escape_modulus u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .start_real_i     (start_real),
    .start_imag_i     (start_imag),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .escape_modulus_o (escape_modulus)
  );

  julia_escape_modulus_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .start_real_i     (start_real),
    .start_imag_i     (start_imag),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .escape_modulus_i (escape_modulus),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .escaped_o        (escaped)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("julia_escape_modulus verification failed");
    $finish;
  end

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [DataW-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    end
    if (r < 8) begin
      return $urandom;
    end
    if (r == 8) begin
      case ($urandom_range(0, 4))
        0: return WordMax;
        1: return WordMin;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic signed [DataW-1:0] pick_c();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    end
    if (r < 9) begin
      return $urandom;
    end
    case ($urandom_range(0, 2))
      0: return WordMax;
      1: return WordMin;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic [ModW-1:0] pick_radius();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return RadiusThree;
    end
    if (r < 6) begin
      return RadiusTwo;
    end
    if (r == 6) begin
      return 31'($urandom_range(0, 32'h4000_0000));
    end
    if (r == 7) begin
      return 31'($urandom);
    end
    if (r == 8) begin
      return '0;
    end
    return 31'h7FFF_FFFF;
  endfunction

  function automatic logic [IterCfgW-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return 16'd1;
    end
    if (r < 15) begin
      return 16'($urandom_range(2, 24));
    end
    if (r < 18) begin
      return 16'($urandom_range(25, 100));
    end
    return 16'($urandom_range(101, 300));
  endfunction

  task automatic send_point(input logic signed [DataW-1:0] sr,
                            input logic signed [DataW-1:0] si);
    int unsigned gap;
    gap = no_idle ? 0 : idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    start_real <= sr;
    start_imag <= si;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [IterCfgW-1:0]   lim,
                                input logic signed [DataW-1:0] cr,
                                input logic signed [DataW-1:0] ci,
                                input logic [ModW-1:0]         rad);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ITER;
    cfg_data  <= {16'($urandom), lim};
    @(negedge clk);
    cfg_index <= CFG_C_REAL;
    cfg_data  <= cr;
    @(negedge clk);
    cfg_index <= CFG_C_IMAG;
    cfg_data  <= ci;
    @(negedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_data  <= {1'($urandom), rad};
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    hold_offs = 0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_stall    <= 1'b1;
        hold_offs++;
        repeat (HoldOffCycles) @(negedge clk);
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        repeat (idle_span() + 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_len;
    int unsigned phase_idx;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MAX_ITER;
    cfg_data         = '0;
    in_valid         = 1'b0;
    start_real       = '0;
    start_imag       = '0;
    no_idle          = 1'b0;
    hold_off_req     = 1'b0;
    items_sent       = 0;
    settings_applied = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: zero limit
    send_point(32'sd0, 32'sd0);
    send_point(WordMax, WordMin);
    drain();

    // zero radius with the largest limit
    apply_settings(16'hFFFF, WordMax, WordMin, '0);
    send_point(32'sd1, -32'sd1);
    send_point(WordMin, WordMax);
    drain();

    // huge constant, saturated modulus on the first step
    apply_settings(16'hFFFF, WordMax, WordMin, 31'h7FFF_FFFF);
    send_point(32'sd0, 32'sd0);
    send_point(WordMax, WordMax);
    send_point(WordMin, WordMin);
    send_point(-32'sd1, 32'sd1);
    drain();

    // escape on the last allowed step
    apply_settings(16'd1, 32'sd0, 32'sd0, RadiusThree);
    send_point(WordMax, 32'sd0);
    send_point(32'sd0, 32'sd0);
    drain();

    // start point outside the radius is not tested
    apply_settings(16'd3, WordMin, 32'sd0, RadiusThree);
    send_point(QThree, 32'sd0);
    send_point(WordMax, WordMax);
    drain();

    // ordinary julia constant, receiver held off while points keep coming
    apply_settings(16'd20, CRealDemo, CImagDemo, RadiusTwo);
    hold_off_req <= 1'b1;
    send_point(32'sd0, 32'sd0);
    send_point(QHalf, QHalf);
    send_point(-(QHalf * 3), 32'sd0);
    send_point(32'sh0500_0000, -32'sh0999_9999);
    repeat (4) send_point(pick_coord(), pick_coord());
    drain();

    phase_idx = 0;
    while (items_sent < TotalItems) begin
      apply_settings(pick_limit(), pick_c(), pick_c(), pick_radius());
      no_idle <= (phase_idx == 2) || ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        hold_off_req <= 1'b1;
      end
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) send_point(pick_coord(), pick_coord());
      drain();
      phase_idx++;
    end
    no_idle <= 1'b0;
    repeat (TailCycles) @(negedge clk);

    $display("summary: %0d point transfers over %0d register settings, %0d escaped early",
             items_sent, settings_applied, escaped);
    $display("summary: limits from 0 to 65535, %0d long output hold-offs", hold_offs);
    if (fail_count == 0 && pending == 0) begin
      $display("julia_escape_modulus verification clean");
    end else begin
      $display("julia_escape_modulus verification failed");
    end
    $finish;
  end

endmodule
